>>> hdl/rrps_pkg.sv
// shared types and constants of the round-robin process scheduler
// no dependencies
package rrps_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned TIME_W = 24;
  localparam int unsigned SUM_W  = 28;
  localparam int unsigned PIDX_W = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [DATA_W-1:0] QUANTUM_RESET = 16'd4;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_RD,
    ST_RUN,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    PH_PRE,
    PH_JUMP,
    PH_POST,
    PH_AFTER
  } phase_e;

  typedef struct packed {
    op_e               operation;
    logic [DATA_W-1:0] burst_time;
    logic [DATA_W-1:0] arrival_time;
  } item_t;

  typedef struct packed {
    logic [PIDX_W-1:0] process_index;
    logic [TIME_W-1:0] slice_end_time;
    logic              finished;
    logic [TIME_W-1:0] wait_time;
    logic [SUM_W-1:0]  total_wait;
    logic              all_done;
  } res_t;

endpackage

>>> hdl/rrps_front.sv
// front part: accepts items, drops loads beyond capacity, two-entry item queue
// depends on rrps_pkg
module rrps_front import rrps_pkg::*; #(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  item_vld_o,
  input  logic  item_rdy_i,
  output item_t item_o
);

  localparam int unsigned CW = $clog2(MAX_PROCS + 1);

  item_t          fifo_mem [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [CW-1:0]  lcnt_q, lcnt_d;
  logic           accept, keep, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign accept     = in_valid_i && in_ready_o;
  // loads past a full store are taken and thrown away
  assign keep = accept && !((in_item_i.operation == OP_LOAD) &&
                            (lcnt_q == CW'(MAX_PROCS)));
  assign item_vld_o = (cnt_q != 2'd0);
  assign pop        = item_vld_o && item_rdy_i;
  assign item_o     = fifo_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    lcnt_d   = lcnt_q;
    if (keep) begin
      wr_ptr_d = ~wr_ptr_q;
      if (in_item_i.operation == OP_LOAD) begin
        lcnt_d = lcnt_q + 1'b1;
      end
    end
    if (pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    cnt_d = cnt_q + {1'b0, keep} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      fifo_mem[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      lcnt_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      lcnt_q   <= lcnt_d;
    end
  end

endmodule

>>> hdl/rrps_back.sv
// back part: process stores, ready ring, admission scans, slice execution
// depends on rrps_pkg
module rrps_back import rrps_pkg::*; #(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DATA_W-1:0] quantum_i,
  input  logic              item_vld_i,
  output logic              item_rdy_o,
  input  item_t             item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output res_t              res_o
);

  localparam int unsigned IW = $clog2(MAX_PROCS);
  localparam int unsigned CW = $clog2(MAX_PROCS + 1);
  localparam int unsigned SW = CW + 1;

  logic [DATA_W-1:0] arr_mem  [MAX_PROCS];
  logic [DATA_W-1:0] bur_mem  [MAX_PROCS];
  logic [DATA_W-1:0] rem_mem  [MAX_PROCS];
  logic [IW-1:0]     ring_mem [MAX_PROCS];

  state_e            state_q, state_d;
  phase_e            ph_q, ph_d;
  logic [CW-1:0]     scan_idx_q, scan_idx_d;
  logic              pipe_vld_q, pipe_vld_d;
  logic [IW-1:0]     pipe_idx_q, pipe_idx_d;
  logic              found_q, found_d;
  logic [IW-1:0]     best_idx_q, best_idx_d;
  logic [DATA_W-1:0] best_arr_q, best_arr_d;
  logic [IW-1:0]     head_q, head_d;
  logic [CW-1:0]     qcnt_q, qcnt_d;
  logic [CW-1:0]     loaded_q, loaded_d;
  logic [MAX_PROCS-1:0] queued_q, queued_d;
  logic [MAX_PROCS-1:0] done_q, done_d;
  logic [TIME_W-1:0] cur_q, cur_d;
  logic [SUM_W-1:0]  wsum_q, wsum_d;
  logic [IW-1:0]     p_q, p_d;
  logic [DATA_W-1:0] arr_p_q, arr_p_d;
  logic [DATA_W-1:0] bur_p_q, bur_p_d;
  logic              fin_q, fin_d;
  logic              out_vld_q, out_vld_d;
  res_t              res_q, res_d;

  logic [IW-1:0]     ring_rd_q;
  logic [DATA_W-1:0] arr_rd_q, bur_rd_q, rem_rd_q;

  logic              accept, scan_end, eligible, better;
  logic [IW-1:0]     rd_addr;
  logic              load_we, rem_we, push_en;
  logic [IW-1:0]     rem_wa, push_data, tail;
  logic [DATA_W-1:0] rem_wd;
  logic [SW-1:0]     tail_sum;
  logic [DATA_W-1:0] q_eff, run;
  logic [TIME_W:0]   cur_sum;
  logic [DATA_W:0]   used;
  logic [TIME_W-1:0] wait_v;
  logic [SUM_W:0]    wsum_sum;
  logic              all_v;
  logic [IW+PIDX_W-1:0] p_ext;

  assign item_rdy_o = (state_q == ST_IDLE) &&
                      ((item_i.operation == OP_LOAD) || !out_vld_q);
  assign accept     = item_vld_i && item_rdy_o;
  assign scan_end   = (scan_idx_q == loaded_q) && !pipe_vld_q;
  assign eligible   = pipe_vld_q && !queued_q[pipe_idx_q] && !done_q[pipe_idx_q] &&
                      ((ph_q == PH_JUMP) || ({8'b0, arr_rd_q} <= cur_q));
  assign better     = eligible && (!found_q || (arr_rd_q < best_arr_q));
  assign tail_sum   = SW'(head_q) + SW'(qcnt_q);
  assign tail       = (tail_sum >= SW'(MAX_PROCS)) ? IW'(tail_sum - SW'(MAX_PROCS))
                                                   : IW'(tail_sum);
  assign q_eff      = (quantum_i == '0) ? 16'd1 : quantum_i;
  assign run        = (rem_rd_q < q_eff) ? rem_rd_q : q_eff;
  assign cur_sum    = {1'b0, cur_q} + {9'b0, run};
  assign used       = {1'b0, arr_p_q} + {1'b0, bur_p_q};
  assign wait_v     = (cur_q > {7'b0, used}) ? (cur_q - {7'b0, used}) : '0;
  assign wsum_sum   = {1'b0, wsum_q} + {5'b0, wait_v};
  assign p_ext      = {{PIDX_W{1'b0}}, p_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (item_i.operation == OP_STEP)) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end && !(found_q && (ph_q != PH_JUMP))) begin
          case (ph_q)
            PH_PRE:   state_d = (qcnt_q != '0) ? ST_POP : ST_SCAN;
            PH_JUMP:  state_d = found_q ? ST_SCAN : ST_IDLE;
            PH_POST:  state_d = (qcnt_q != '0) ? ST_POP : ST_IDLE;
            PH_AFTER: state_d = ST_FIN;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_POP:  state_d = ST_RD;
      ST_RD:   state_d = ST_RUN;
      ST_RUN:  state_d = ST_SCAN;
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and controls
  always_comb begin
    ph_d       = ph_q;
    scan_idx_d = scan_idx_q;
    pipe_vld_d = pipe_vld_q;
    pipe_idx_d = pipe_idx_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_arr_d = best_arr_q;
    head_d     = head_q;
    qcnt_d     = qcnt_q;
    loaded_d   = loaded_q;
    queued_d   = queued_q;
    done_d     = done_q;
    cur_d      = cur_q;
    wsum_d     = wsum_q;
    p_d        = p_q;
    arr_p_d    = arr_p_q;
    bur_p_d    = bur_p_q;
    fin_d      = fin_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    res_d      = res_q;
    rd_addr    = '0;
    load_we    = 1'b0;
    rem_we     = 1'b0;
    rem_wa     = p_q;
    rem_wd     = rem_rd_q - run;
    push_en    = 1'b0;
    push_data  = p_q;
    all_v      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_i.operation == OP_LOAD) begin
            load_we  = 1'b1;
            rem_wa   = IW'(loaded_q);
            rem_wd   = item_i.burst_time;
            rem_we   = 1'b1;
            loaded_d = loaded_q + 1'b1;
          end else begin
            ph_d       = PH_PRE;
            scan_idx_d = '0;
            pipe_vld_d = 1'b0;
            found_d    = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (!scan_end) begin
          if (scan_idx_q < loaded_q) begin
            rd_addr    = IW'(scan_idx_q);
            pipe_vld_d = 1'b1;
            pipe_idx_d = IW'(scan_idx_q);
            scan_idx_d = scan_idx_q + 1'b1;
          end else begin
            pipe_vld_d = 1'b0;
          end
          if (better) begin
            found_d    = 1'b1;
            best_idx_d = pipe_idx_q;
            best_arr_d = arr_rd_q;
          end
        end else begin
          scan_idx_d = '0;
          pipe_vld_d = 1'b0;
          found_d    = 1'b0;
          if (found_q && (ph_q != PH_JUMP)) begin
            queued_d[best_idx_q] = 1'b1;
            push_en   = 1'b1;
            push_data = best_idx_q;
          end else if ((ph_q == PH_PRE) && (qcnt_q == '0)) begin
            ph_d = PH_JUMP;
          end else if ((ph_q == PH_JUMP) && found_q) begin
            // idle gap: jump the clock to the next arrival
            if ({8'b0, best_arr_q} > cur_q) cur_d = {8'b0, best_arr_q};
            ph_d = PH_POST;
          end
        end
      end
      ST_POP: begin
        head_d = (head_q == IW'(MAX_PROCS - 1)) ? '0 : head_q + 1'b1;
        qcnt_d = qcnt_q - 1'b1;
      end
      ST_RD: begin
        rd_addr = ring_rd_q;
        p_d     = ring_rd_q;
      end
      ST_RUN: begin
        cur_d      = cur_sum[TIME_W] ? TIME_MAX : cur_sum[TIME_W-1:0];
        rem_we     = 1'b1;
        arr_p_d    = arr_rd_q;
        bur_p_d    = bur_rd_q;
        fin_d      = (rem_rd_q == run);
        ph_d       = PH_AFTER;
        scan_idx_d = '0;
        pipe_vld_d = 1'b0;
        found_d    = 1'b0;
      end
      ST_FIN: begin
        res_d.process_index  = p_ext[PIDX_W-1:0];
        res_d.slice_end_time = cur_q;
        res_d.finished       = fin_q;
        if (fin_q) begin
          wsum_d          = wsum_sum[SUM_W] ? SUM_MAX : wsum_sum[SUM_W-1:0];
          done_d[p_q]     = 1'b1;
          queued_d[p_q]   = 1'b0;
          res_d.wait_time = wait_v;
        end else begin
          push_en         = 1'b1;
          res_d.wait_time = '0;
        end
        res_d.total_wait = wsum_d;
        all_v = (loaded_q != '0);
        for (int i = 0; i < MAX_PROCS; i++) begin
          if ((CW'(i) < loaded_q) && !done_d[i]) all_v = 1'b0;
        end
        res_d.all_done = all_v;
        out_vld_d      = 1'b1;
      end
      default: ;
    endcase

    if (push_en && (qcnt_q < CW'(MAX_PROCS))) begin
      qcnt_d = qcnt_q + 1'b1;
    end else begin
      push_en = push_en && 1'b0;
    end
  end

  // process stores and ready ring
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      arr_mem[IW'(loaded_q)] <= item_i.arrival_time;
      bur_mem[IW'(loaded_q)] <= item_i.burst_time;
    end
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    if (push_en) begin
      ring_mem[tail] <= push_data;
    end
    arr_rd_q  <= arr_mem[rd_addr];
    bur_rd_q  <= bur_mem[rd_addr];
    rem_rd_q  <= rem_mem[rd_addr];
    ring_rd_q <= ring_mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    pipe_idx_q <= pipe_idx_d;
    best_idx_q <= best_idx_d;
    best_arr_q <= best_arr_d;
    p_q        <= p_d;
    arr_p_q    <= arr_p_d;
    bur_p_q    <= bur_p_d;
    fin_q      <= fin_d;
    res_q      <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ph_q       <= PH_PRE;
      scan_idx_q <= '0;
      pipe_vld_q <= 1'b0;
      found_q    <= 1'b0;
      head_q     <= '0;
      qcnt_q     <= '0;
      loaded_q   <= '0;
      queued_q   <= '0;
      done_q     <= '0;
      cur_q      <= '0;
      wsum_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ph_q       <= ph_d;
      scan_idx_q <= scan_idx_d;
      pipe_vld_q <= pipe_vld_d;
      found_q    <= found_d;
      head_q     <= head_d;
      qcnt_q     <= qcnt_d;
      loaded_q   <= loaded_d;
      queued_q   <= queued_d;
      done_q     <= done_d;
      cur_q      <= cur_d;
      wsum_q     <= wsum_d;
      out_vld_q  <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

`ifndef SYNTH
  a_qcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q <= CW'(MAX_PROCS))
    else $error("ready ring count beyond depth");

  a_masks_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (queued_q & done_q) == '0)
    else $error("process both queued and done");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside the finish step");

  a_loaded_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= CW'(MAX_PROCS))
    else $error("loaded count beyond store depth");
`endif

endmodule

>>> hdl/round_robin_process_scheduler_core.sv
// round-robin scheduler core: a load is queued in the front part, then written to the stores by the back part
// a step runs admission passes over the L loaded processes until none is admitted, then pops
// the ready ring, runs a slice and admits arrivals up to the new slice end before it reports,
// with two passes more when the ring is empty and the clock jumps over an idle gap
// one item is worked on at a time; results wait in an output register
// asynchronous active-low reset clears control state and sets quantum to 4; stores not cleared
module round_robin_process_scheduler_core import rrps_pkg::*; #(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    operation_i,
  input  logic [DATA_W-1:0]       burst_time_i,
  input  logic [DATA_W-1:0]       arrival_time_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [PIDX_W-1:0]       process_index_o,
  output logic [TIME_W-1:0]       slice_end_time_o,
  output logic                    finished_o,
  output logic [TIME_W-1:0]       wait_time_o,
  output logic [SUM_W-1:0]        total_wait_o,
  output logic                    all_done_o
);

  logic [DATA_W-1:0] quantum_q, quantum_d;
  item_t             in_item, q_item;
  logic              q_vld, q_rdy;
  res_t              res;

  // register block: quantum at byte address 0
  assign pready    = 1'b1;
  assign quantum_d = (psel && penable && pwrite && !paddr[2]) ? pwdata[DATA_W-1:0]
                                                              : quantum_q;
  assign prdata    = !paddr[2] ? {16'b0, quantum_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RESET;
    end else begin
      quantum_q <= quantum_d;
    end
  end

  assign in_item.operation    = op_e'(operation_i);
  assign in_item.burst_time   = burst_time_i;
  assign in_item.arrival_time = arrival_time_i;

  rrps_front #(.MAX_PROCS(MAX_PROCS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .item_vld_o (q_vld),
    .item_rdy_i (q_rdy),
    .item_o     (q_item)
  );

  rrps_back #(.MAX_PROCS(MAX_PROCS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .quantum_i   (quantum_q),
    .item_vld_i  (q_vld),
    .item_rdy_o  (q_rdy),
    .item_i      (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign process_index_o  = res.process_index;
  assign slice_end_time_o = res.slice_end_time;
  assign finished_o       = res.finished;
  assign wait_time_o      = res.wait_time;
  assign total_wait_o     = res.total_wait;
  assign all_done_o       = res.all_done;

endmodule
